// ===== rtl/core/voxel_occupancy_grid_engine_macros.svh =====
// Assertion helpers
`ifndef VOXEL_OCCUPANCY_GRID_ENGINE_MACROS_SVH
`define VOXEL_OCCUPANCY_GRID_ENGINE_MACROS_SVH
`define VOG_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define VOG_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/vog_pkg.sv =====
`timescale 1ns / 1ps
package vog_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned SizeW = 16;
  localparam int unsigned IdxW = 20;
  localparam int unsigned CntW = 25;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_X = 3'd0, CFG_MIN_Y = 3'd1, CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3, CFG_MAX_Y = 3'd4, CFG_MAX_Z = 3'd5,
    CFG_CELL = 3'd6, CFG_RADIUS = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    logic [CoordW+1:0] num;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [CoordW+1:0] quot;
  } div_rsp_t;
endpackage

// ===== rtl/core/vog_if.sv =====
`timescale 1ns / 1ps
interface vog_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  modport source (output valid, req_type, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, output ready);
endinterface

interface vog_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic out_of_map;
  logic grid_too_large;
  logic [19:0] cell_index;
  modport source (output valid, hit, out_of_map, grid_too_large, cell_index, input ready);
  modport sink (input valid, hit, out_of_map, grid_too_large, cell_index, output ready);
endinterface

// ===== rtl/core/vog_div.sv =====
`timescale 1ns / 1ps
// ceil(num / den), one quotient bit per cycle
module vog_div (
  input  logic clk,
  input  logic rst,
  input  vog_pkg::div_req_t req,
  input  logic [vog_pkg::SizeW-1:0] den,
  output vog_pkg::div_rsp_t rsp
);
  localparam int unsigned NW = vog_pkg::CoordW + 2;
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [vog_pkg::SizeW:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic [vog_pkg::SizeW:0] trial;
  logic [vog_pkg::SizeW:0] d;

  always_comb begin
    d = {1'b0, (den == '0) ? vog_pkg::SizeW'(1) : den};
    trial = {rem[vog_pkg::SizeW-1:0], q[NW-1]};
  end

  always_ff @(posedge clk) begin
    logic done_v;
    done_v = 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      q <= req.num;
      rem <= '0;
      cnt <= CW'(NW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done_v = 1'b1;
        rsp.quot <= q + NW'(rem != '0);
      end else begin
        cnt <= cnt - CW'(1);
        if (trial >= d) begin
          rem <= trial - d;
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
      end
    end
    rsp.done <= done_v;
  end
endmodule

// ===== rtl/core/vog_store.sv =====
`timescale 1ns / 1ps
// occupancy bitmap with clearing pass
module vog_store #(
  parameter int unsigned Depth = 1048576
) (
  input  logic clk,
  input  logic rst,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  output logic rdata,
  output logic clearing
);
  localparam int unsigned AW = $clog2(Depth);
  logic mem [Depth];
  logic [AW:0] clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      mem[clr[AW-1:0]] <= 1'b0;
      clr <= clr + (AW+1)'(1);
      if (clr == (AW+1)'(Depth - 1)) clearing <= 1'b0;
    end else if (we) begin
      mem[addr] <= 1'b1;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/voxel_occupancy_grid_engine.sv =====
`timescale 1ns / 1ps
// Occupancy bitmap over a box, MAX_CELLS one-bit cells in one memory. After
// reset a clearing pass over all MAX_CELLS cells runs before any item is taken.
// A configuration write triggers a rederive of the cell counts (up to three
// serial divisions). Insert and query divide by the cell size on each axis
// (up to three divisions) and then access the memory.
// A collision check divides once per x probe, and for each distinct x column
// once per y probe, reading one cell per probe pair, until a probe leaves the
// box or a set cell is found. One item is in flight at a time; the result is
// held until it is taken.
module voxel_occupancy_grid_engine #(
  parameter int unsigned MAX_CELLS = 1048576,
  parameter int unsigned SWEEP_STEP_MM = 100
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [vog_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vog_pkg::CfgDataW-1:0] cfg_data,
  vog_req_if.sink req,
  vog_rsp_if.source rsp
);
  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned NW = vog_pkg::CoordW + 2;
  localparam int unsigned CW = vog_pkg::CntW;
  localparam int unsigned PW = 2 * CW;

  typedef enum logic [4:0] {
    S_DERIVE, S_DWAIT, S_DPROD1, S_DPROD2, S_IDLE, S_AX, S_AXW, S_LIN1, S_LIN2,
    S_MEM, S_MEMW, S_OUT, S_CZ, S_PX, S_PXW, S_PY, S_PYW, S_RD1,
    S_RD2, S_RDW, S_RDA, S_RDB, S_FIN
  } state_t;

  state_t state;
  logic signed [NW-1:0] lo [3];
  logic signed [NW-1:0] hi [3];
  logic [vog_pkg::SizeW-1:0] cell_mm;
  logic [vog_pkg::SizeW-1:0] radius;
  logic signed [NW-1:0] rad_s;
  logic [CW-1:0] cnt [3];
  logic too_large;
  logic [1:0] ax;
  logic [PW-1:0] prod;
  logic [1:0] rtype;
  logic signed [NW-1:0] pos [3];
  logic in_box;
  logic [CW-1:0] ci [3];
  logic [PW-1:0] lin;
  logic [PW-1:0] ci_lin;
  logic hit_r;
  vog_pkg::div_req_t dreq;
  vog_pkg::div_rsp_t drsp;
  logic we;
  logic [AW-1:0] addr;
  logic rdata;
  logic clearing;
  // sweep
  logic signed [NW-1:0] offx, offy;
  logic [CW-1:0] colx, coly, lastx;
  logic firstx;
  logic signed [NW-1:0] probe;
  logic pin;

  vog_div u_div (.clk(clk), .rst(rst || cfg_we), .req(dreq), .den(cell_mm), .rsp(drsp));
  vog_store #(.Depth(MAX_CELLS)) u_store (
    .clk(clk), .rst(rst), .we(we), .addr(addr), .rdata(rdata), .clearing(clearing)
  );

  function automatic logic [vog_pkg::IdxW-1:0] pos_idx(logic ins, logic tl,
                                                       logic [PW-1:0] l);
    return (ins && !tl) ? l[vog_pkg::IdxW-1:0] : '0;
  endfunction

  assign rad_s = signed'(NW'(radius));

  always_comb begin
    unique case (state)
      S_PX, S_PXW: probe = pos[0] + offx;
      S_PY, S_PYW: probe = pos[1] + offy;
      default: probe = pos[ax];
    endcase
  end
  always_comb begin
    unique case (state)
      S_PX, S_PXW: pin = (probe >= lo[0]) && (probe <= hi[0]);
      S_PY, S_PYW: pin = (probe >= lo[1]) && (probe <= hi[1]);
      default: pin = (probe >= lo[ax]) && (probe <= hi[ax]);
    endcase
  end

  assign req.ready = (state == S_IDLE) && !clearing && !rsp.valid;

  always_ff @(posedge clk) begin
    logic start_v;
    logic we_v;
    start_v = 1'b0;
    we_v = 1'b0;
    if (rst) begin
      state <= S_DERIVE;
      rsp.valid <= 1'b0;
      lo[0] <= '0; lo[1] <= '0; lo[2] <= '0;
      hi[0] <= NW'(10000); hi[1] <= NW'(10000); hi[2] <= NW'(3000);
      cell_mm <= vog_pkg::SizeW'(100);
      radius <= vog_pkg::SizeW'(2000);
      ax <= '0;
      too_large <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (cfg_we) begin
        unique case (vog_pkg::cfg_idx_t'(cfg_index))
          vog_pkg::CFG_MIN_X: lo[0] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_MIN_Y: lo[1] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_MIN_Z: lo[2] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_MAX_X: hi[0] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_MAX_Y: hi[1] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_MAX_Z: hi[2] <= NW'(signed'(cfg_data));
          vog_pkg::CFG_CELL: cell_mm <= cfg_data[vog_pkg::SizeW-1:0];
          vog_pkg::CFG_RADIUS: radius <= cfg_data[vog_pkg::SizeW-1:0];
          default: ;
        endcase
        state <= S_DERIVE;
        ax <= '0;
      end else begin
        unique case (state)
          S_DERIVE: begin
            if (hi[ax] < lo[ax]) begin
              cnt[ax] <= '0;
              if (ax == 2'd2) state <= S_DPROD1;
              else ax <= ax + 2'd1;
            end else begin
              dreq.num <= NW'(hi[ax] - lo[ax]);
              start_v = 1'b1;
              state <= S_DWAIT;
            end
          end
          S_DWAIT: if (drsp.done) begin
            cnt[ax] <= CW'(drsp.quot) + CW'(1);
            if (ax == 2'd2) state <= S_DPROD1;
            else begin
              ax <= ax + 2'd1;
              state <= S_DERIVE;
            end
          end
          S_DPROD1: begin
            prod <= PW'(cnt[0]) * PW'(cnt[1]);
            state <= S_DPROD2;
          end
          S_DPROD2: begin
            if (cnt[0] == '0 || cnt[1] == '0 || cnt[2] == '0) too_large <= 1'b0;
            else too_large <= (prod > PW'(MAX_CELLS)) ||
                  (PW'(prod[CW-1:0]) * PW'(cnt[2]) > PW'(MAX_CELLS));
            state <= S_IDLE;
          end
          S_IDLE: if (req.valid && req.ready) begin
            rtype <= req.req_type;
            pos[0] <= NW'(req.pos_x);
            pos[1] <= NW'(req.pos_y);
            pos[2] <= NW'(req.pos_z);
            in_box <= 1'b1;
            ax <= '0;
            hit_r <= 1'b0;
            state <= S_AX;
          end
          S_AX: begin
            if (!pin || too_large) begin
              if (!pin) in_box <= 1'b0;
              ci[ax] <= '0;
              if (ax == 2'd2) state <= S_LIN1;
              else ax <= ax + 2'd1;
            end else begin
              dreq.num <= NW'(pos[ax] - lo[ax]);
              start_v = 1'b1;
              state <= S_AXW;
            end
          end
          S_AXW: if (drsp.done) begin
            ci[ax] <= CW'(drsp.quot);
            if (ax == 2'd2) state <= S_LIN1;
            else begin
              ax <= ax + 2'd1;
              state <= S_AX;
            end
          end
          S_LIN1: begin
            lin <= PW'(ci[1]) + PW'(cnt[1]) * PW'(ci[2]);
            state <= S_LIN2;
          end
          S_LIN2: begin
            lin <= PW'(ci[0]) + PW'(cnt[0]) * PW'(lin[CW-1:0]);
            state <= S_MEM;
          end
          S_MEM: begin
            if (!in_box || too_large) lin <= '0;
            ci_lin <= (!in_box || too_large) ? '0 : lin;
            addr <= lin[AW-1:0];
            we_v = (rtype == vog_pkg::REQ_INSERT) && in_box && !too_large &&
                   (lin < PW'(MAX_CELLS));
            state <= S_MEMW;
          end
          S_MEMW: begin
            state <= S_OUT;
          end
          S_OUT: begin
            if (rtype == vog_pkg::REQ_QUERY)
              hit_r <= in_box && !too_large && (lin < PW'(MAX_CELLS)) && rdata;
            if (rtype == vog_pkg::REQ_CHECK) begin
              ax <= 2'd2;
              state <= S_CZ;
            end else state <= S_FIN;
          end
          S_CZ: begin
            if (!pin) begin
              hit_r <= 1'b1;
              state <= S_FIN;
            end else begin
              offx <= -rad_s;
              firstx <= 1'b1;
              state <= S_PX;
            end
          end
          S_PX: begin
            if (offx > rad_s) begin
              state <= S_FIN;
            end else if (!pin) begin
              hit_r <= 1'b1;
              state <= S_FIN;
            end else begin
              dreq.num <= NW'(probe - lo[0]);
              start_v = 1'b1;
              state <= S_PXW;
            end
          end
          S_PXW: if (drsp.done) begin
            colx <= CW'(drsp.quot);
            if (!firstx && CW'(drsp.quot) == lastx) begin
              offx <= offx + NW'(SWEEP_STEP_MM);
              state <= S_PX;
            end else begin
              firstx <= 1'b0;
              lastx <= CW'(drsp.quot);
              offy <= -rad_s;
              state <= S_PY;
            end
          end
          S_PY: begin
            if (offy > rad_s) begin
              offx <= offx + NW'(SWEEP_STEP_MM);
              state <= S_PX;
            end else if (!pin) begin
              hit_r <= 1'b1;
              state <= S_FIN;
            end else begin
              dreq.num <= NW'(probe - lo[1]);
              start_v = 1'b1;
              state <= S_PYW;
            end
          end
          S_PYW: if (drsp.done) begin
            coly <= CW'(drsp.quot);
            offy <= offy + NW'(SWEEP_STEP_MM);
            state <= too_large ? S_PY : S_RD1;
          end
          S_RD1: begin
            lin <= PW'(coly) + PW'(cnt[1]) * PW'(ci[2]);
            state <= S_RD2;
          end
          S_RD2: begin
            lin <= PW'(colx) + PW'(cnt[0]) * PW'(lin[CW-1:0]);
            state <= S_RDW;
          end
          S_RDW: begin
            addr <= lin[AW-1:0];
            state <= S_RDA;
          end
          S_RDA: begin
            state <= S_RDB;
          end
          S_RDB: begin
            if (rdata) begin
              hit_r <= 1'b1;
              state <= S_FIN;
            end else state <= S_PY;
          end
          S_FIN: begin
            if (!rsp.valid) begin
              rsp.valid <= 1'b1;
              rsp.hit <= hit_r;
              rsp.out_of_map <= (rtype == vog_pkg::REQ_NONE) ? 1'b0 : !in_box;
              rsp.grid_too_large <= too_large;
              rsp.cell_index <= (rtype == vog_pkg::REQ_NONE) ? '0 :
                                pos_idx(in_box, too_large, ci_lin);
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
    dreq.start <= start_v;
    we <= we_v;
  end
endmodule

// ===== rtl/core/vog_checker.sv =====
`timescale 1ns / 1ps
`include "voxel_occupancy_grid_engine_macros.svh"
module vog_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_of_map,
  input logic [19:0] cell_index
);
  `VOG_ASSERT_IMPL(a_idx_zero_out, clk, rst, out_valid && out_of_map, cell_index == 20'd0)
  `VOG_ASSERT_IMPL(a_no_take_busy, clk, rst, out_valid, !in_ready)
  `VOG_ASSERT_NEXT(a_take_busy, clk, rst, in_valid && in_ready, !in_ready)
  `VOG_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && !out_ready, out_valid && $stable(cell_index))
endmodule

bind voxel_occupancy_grid_engine vog_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_of_map(rsp.out_of_map),
  .cell_index(rsp.cell_index)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam longint GRID_CELLS = 1048576;
  localparam longint STEP_MM = 100;
  localparam longint CYCLE_LIMIT = 40000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    bit hit;
    bit out_of_map;
    bit too_large;
    bit [19:0] cell_index;
  } grid_result_t;

  class scoreboard_t;
    longint lo[3];
    longint hi[3];
    longint cnt[3];
    longint cell_mm;
    longint radius;
    bit big;
    bit occ[longint];
    grid_result_t expected_q[$];
    int errors;
    int checked;
    int hits;

    function new();
      lo[0] = 0; lo[1] = 0; lo[2] = 0;
      hi[0] = 10000; hi[1] = 10000; hi[2] = 3000;
      cell_mm = 100;
      radius = 2000;
      errors = 0;
      checked = 0;
      hits = 0;
      derive();
    endfunction

    function longint cell_edge();
      return (cell_mm == 0) ? 1 : cell_mm;
    endfunction

    function void derive();
      longint d;
      longint p;
      big = 0;
      for (int a = 0; a < 3; a++) begin
        d = hi[a] - lo[a];
        cnt[a] = (d < 0) ? 0 : (d + cell_edge() - 1) / cell_edge() + 1;
      end
      if (cnt[0] == 0 || cnt[1] == 0 || cnt[2] == 0) return;
      p = cnt[0];
      if (p > GRID_CELLS) begin big = 1; return; end
      p = p * cnt[1];
      if (p > GRID_CELLS) begin big = 1; return; end
      p = p * cnt[2];
      if (p > GRID_CELLS) big = 1;
    endfunction

    function void set_reg(vog_pkg::cfg_idx_t i, logic [23:0] v);
      case (i)
        vog_pkg::CFG_MIN_X: lo[0] = longint'($signed(v));
        vog_pkg::CFG_MIN_Y: lo[1] = longint'($signed(v));
        vog_pkg::CFG_MIN_Z: lo[2] = longint'($signed(v));
        vog_pkg::CFG_MAX_X: hi[0] = longint'($signed(v));
        vog_pkg::CFG_MAX_Y: hi[1] = longint'($signed(v));
        vog_pkg::CFG_MAX_Z: hi[2] = longint'($signed(v));
        vog_pkg::CFG_CELL: cell_mm = longint'(v[15:0]);
        vog_pkg::CFG_RADIUS: radius = longint'(v[15:0]);
        default: ;
      endcase
      derive();
    endfunction

    function bit in_axis(int a, longint v);
      return v >= lo[a] && v <= hi[a];
    endfunction

    function longint axis_cell(int a, longint v);
      return (v - lo[a] + cell_edge() - 1) / cell_edge();
    endfunction

    function longint linear(longint ix, longint iy, longint iz);
      return ix + cnt[0] * (iy + cnt[1] * iz);
    endfunction

    function bit read_cell(longint idx);
      if (idx >= GRID_CELLS) return 0;
      return occ.exists(idx) ? occ[idx] : 1'b0;
    endfunction

    function bit sweep_axis(int a, longint c, ref longint cols[$]);
      longint p;
      longint ci;
      cols.delete();
      for (longint off = -radius; off <= radius; off += STEP_MM) begin
        p = c + off;
        if (!in_axis(a, p)) return 0;
        ci = axis_cell(a, p);
        if (cols.size() == 0 || cols[$] != ci) cols = {cols, ci};
      end
      return 1;
    endfunction

    function bit collide(longint x, longint y, longint z);
      longint xc[$];
      longint yc[$];
      longint iz;
      if (!in_axis(2, z)) return 1;
      if (!sweep_axis(0, x, xc)) return 1;
      if (!sweep_axis(1, y, yc)) return 1;
      if (big) return 0;
      iz = axis_cell(2, z);
      foreach (xc[i])
        foreach (yc[j])
          if (read_cell(linear(xc[i], yc[j], iz))) return 1;
      return 0;
    endfunction

    function void note_input(vog_pkg::req_t r, logic signed [23:0] px,
                             logic signed [23:0] py, logic signed [23:0] pz);
      longint x;
      longint y;
      longint z;
      longint idx;
      bit in_box;
      grid_result_t e;
      x = longint'(px);
      y = longint'(py);
      z = longint'(pz);
      in_box = in_axis(0, x) && in_axis(1, y) && in_axis(2, z);
      idx = 0;
      e.hit = 0;
      if (in_box && !big) idx = linear(axis_cell(0, x), axis_cell(1, y), axis_cell(2, z));
      case (r)
        vog_pkg::REQ_INSERT: if (in_box && !big && idx < GRID_CELLS) occ[idx] = 1;
        vog_pkg::REQ_QUERY: e.hit = in_box && !big && read_cell(idx);
        vog_pkg::REQ_CHECK: e.hit = collide(x, y, z);
        default: begin
          in_box = 1;
          idx = 0;
        end
      endcase
      e.out_of_map = !in_box;
      e.too_large = big;
      e.cell_index = idx[19:0];
      expected_q = {expected_q, e};
    endfunction

    function void check_result(grid_result_t act);
      grid_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: hit=%0b oom=%0b big=%0b idx=%0d",
                                   act.hit, act.out_of_map, act.too_large, act.cell_index);
        return;
      end
      e = expected_q.pop_front();
      if (e.hit) hits++;
      if (e != act) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp hit=%0b oom=%0b big=%0b idx=%0d, got %0b %0b %0b %0d",
                   checked, e.hit, e.out_of_map, e.too_large, e.cell_index,
                   act.hit, act.out_of_map, act.too_large, act.cell_index);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [vog_pkg::CfgIdxW-1:0] cfg_index;
  logic [vog_pkg::CfgDataW-1:0] cfg_data;
  vog_req_if req ();
  vog_rsp_if rsp ();

  voxel_occupancy_grid_engine dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  scoreboard_t sb = new();
  bit idle_on = 1;
  bit valid_hi = 0;
  int sent = 0;
  int resp_stall = 0;
  longint cycles = 0;
  logic signed [23:0] stored_x[$];
  logic signed [23:0] stored_y[$];
  logic signed [23:0] stored_z[$];

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready)
        sb.check_result('{rsp.hit, rsp.out_of_map, rsp.grid_too_large, rsp.cell_index});
      if (!idle_on) begin
        rsp.ready <= 1'b1;
      end else if (resp_stall > 0) begin
        resp_stall--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        resp_stall = $urandom_range(1, 19) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send(vog_pkg::req_t r, logic signed [23:0] x, logic signed [23:0] y,
                      logic signed [23:0] z);
    req.valid <= 1'b1;
    req.req_type <= r;
    req.pos_x <= x;
    req.pos_y <= y;
    req.pos_z <= z;
    valid_hi = 1;
    do @(posedge clk); while (!req.ready);
    sb.note_input(r, x, y, z);
    sent++;
    if (r == vog_pkg::REQ_INSERT) begin
      stored_x = {stored_x, x};
      stored_y = {stored_y, y};
      stored_z = {stored_z, z};
    end
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      valid_hi = 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (valid_hi) begin
      req.valid <= 1'b0;
      valid_hi = 0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(vog_pkg::cfg_idx_t i, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(i, v);
  endtask

  task automatic set_box(longint x0, longint y0, longint z0, longint x1, longint y1,
                         longint z1, longint csize, longint rad);
    drain();
    stored_x.delete();
    stored_y.delete();
    stored_z.delete();
    write_reg(vog_pkg::CFG_MIN_X, x0[23:0]);
    write_reg(vog_pkg::CFG_MIN_Y, y0[23:0]);
    write_reg(vog_pkg::CFG_MIN_Z, z0[23:0]);
    write_reg(vog_pkg::CFG_MAX_X, x1[23:0]);
    write_reg(vog_pkg::CFG_MAX_Y, y1[23:0]);
    write_reg(vog_pkg::CFG_MAX_Z, z1[23:0]);
    write_reg(vog_pkg::CFG_CELL, csize[23:0]);
    write_reg(vog_pkg::CFG_RADIUS, rad[23:0]);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_coord(int a);
    longint span;
    longint v;
    int dice;
    span = sb.hi[a] - sb.lo[a];
    dice = $urandom_range(0, 9);
    if (span < 0 || dice == 0) return 24'($urandom());
    if (dice == 1) v = sb.hi[a] + $urandom_range(1, 300);
    else if (dice == 2) v = sb.lo[a] - $urandom_range(1, 300);
    else v = sb.lo[a] + longint'($urandom_range(0, int'(span)));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic random_items(int n);
    int k;
    int dice;
    for (int i = 0; i < n; i++) begin
      dice = $urandom_range(0, 99);
      if (dice < 35 && stored_x.size() > 0) begin
        k = $urandom_range(0, stored_x.size() - 1);
        send((dice < 25) ? vog_pkg::REQ_QUERY : vog_pkg::REQ_CHECK,
             stored_x[k], stored_y[k], stored_z[k]);
      end else if (dice < 70) begin
        send(vog_pkg::REQ_INSERT, pick_coord(0), pick_coord(1), pick_coord(2));
      end else if (dice < 85) begin
        send(vog_pkg::REQ_CHECK, pick_coord(0), pick_coord(1), pick_coord(2));
      end else if (dice < 96) begin
        send(vog_pkg::REQ_QUERY, pick_coord(0), pick_coord(1), pick_coord(2));
      end else begin
        send(vog_pkg::REQ_NONE, 24'($urandom()), 24'($urandom()), 24'($urandom()));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.req_type = vog_pkg::REQ_INSERT;
    req.pos_x = '0;
    req.pos_y = '0;
    req.pos_z = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset box: insert, read back, sweep at default radius, unused code, extremes
    send(vog_pkg::REQ_INSERT, 24'sd5050, 24'sd5050, 24'sd1500);
    send(vog_pkg::REQ_QUERY, 24'sd5050, 24'sd5050, 24'sd1500);
    send(vog_pkg::REQ_QUERY, 24'sd5000, 24'sd5000, 24'sd1500);
    send(vog_pkg::REQ_CHECK, 24'sd5500, 24'sd5500, 24'sd1500);
    send(vog_pkg::REQ_CHECK, 24'sd100, 24'sd5000, 24'sd1500);
    send(vog_pkg::REQ_NONE, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send(vog_pkg::REQ_INSERT, 24'sh800000, 24'sh800000, 24'sh800000);
    send(vog_pkg::REQ_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send(vog_pkg::REQ_INSERT, 24'sd10000, 24'sd10000, 24'sd3000);
    send(vog_pkg::REQ_QUERY, 24'sd10000, 24'sd10000, 24'sd3000);
    send(vog_pkg::REQ_INSERT, 24'sd0, 24'sd0, 24'sd0);
    send(vog_pkg::REQ_QUERY, 24'sd0, 24'sd0, 24'sd0);
    send(vog_pkg::REQ_CHECK, 24'sd5000, 24'sd5000, 24'sd3001);

    // huge radius: the first probe leaves a small box
    set_box(0, 0, 0, 1000, 1000, 100, 100, 65535);
    send(vog_pkg::REQ_CHECK, 24'sd500, 24'sd500, 24'sd50);
    send(vog_pkg::REQ_QUERY, 24'sd1001, 24'sd500, 24'sd50);
    // zero radius probes only the point itself
    set_box(0, 0, 0, 1000, 1000, 100, 100, 0);
    send(vog_pkg::REQ_INSERT, 24'sd550, 24'sd550, 24'sd50);
    send(vog_pkg::REQ_CHECK, 24'sd550, 24'sd550, 24'sd50);
    send(vog_pkg::REQ_CHECK, 24'sd450, 24'sd550, 24'sd50);
    // radius off the step grid: the point itself is skipped
    set_box(0, 0, 0, 1000, 1000, 100, 100, 50);
    send(vog_pkg::REQ_CHECK, 24'sd550, 24'sd550, 24'sd50);
    send(vog_pkg::REQ_CHECK, 24'sd500, 24'sd550, 24'sd50);

    set_box(-1000, -1000, -300, 1000, 1000, 300, 100, 150);
    random_items(65);
    drain();
    random_items(65);

    set_box(0, 0, 0, 15, 15, 3, 0, 0);
    random_items(55);
    set_box(0, 0, 0, 15, 15, 3, 1, 100);
    random_items(55);

    set_box(-8388608, 0, 0, 8388607, 500, 0, 65535, 300);
    random_items(100);

    set_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1, 200);
    random_items(90);

    set_box(500, 0, 0, -500, 1000, 100, 100, 100);
    random_items(60);

    set_box(0, 0, 0, 2550, 2550, 510, 255, 250);
    random_items(180);

    set_box(0, 0, 0, 700, 700, 140, 70, 200);
    idle_on = 0;
    random_items(200);
    drain();

    $display("transfers sent: %0d, results checked: %0d, hits seen: %0d", sent, sb.checked,
             sb.hits);
    $display("covered reset box, small sweeps, zero cell, inverted axis and oversized grid");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vog_pkg.sv
rtl/core/vog_if.sv
rtl/core/vog_div.sv
rtl/core/vog_store.sv
rtl/core/voxel_occupancy_grid_engine.sv
rtl/core/vog_checker.sv
verif/testbench.sv
